// ===== rtl/fmaf_pkg.sv =====
package fmaf_pkg;

	// Field geometry of binary32.
	localparam int unsigned EXP_W  = 8;
	localparam int unsigned FRAC_W = 23;
	localparam int unsigned SIG_W  = FRAC_W + 1;
	localparam int unsigned PROD_W = 2 * SIG_W;
	localparam int unsigned WIDE_W = 64;

	// Internal exponent width, wide enough for every intermediate exponent.
	localparam int unsigned EW = 12;

	localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
	localparam logic [31:0] INF_BITS     = 32'h7F80_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
	localparam logic [EW-1:0] EXP_OFFSET = EW'(150);
	localparam logic [EW-1:0] BIAS_ADJ   = EW'(190);

	typedef logic signed [EW-1:0] exp_t;

	// Early result that bypasses the arithmetic path.
	typedef struct packed {
		logic        hit;
		logic [31:0] val;
	} spec_t;

	function automatic logic [4:0] lzc24(input logic [SIG_W-1:0] x);
		logic [4:0] n;
		n = 5'(SIG_W);
		for (int i = 0; i < SIG_W; i++) begin
			if (x[i]) n = 5'(SIG_W - 1 - i);
		end
		return n;
	endfunction

	function automatic logic [5:0] lzc48(input logic [PROD_W-1:0] x);
		logic [5:0] n;
		n = 6'(PROD_W);
		for (int i = 0; i < PROD_W; i++) begin
			if (x[i]) n = 6'(PROD_W - 1 - i);
		end
		return n;
	endfunction

	function automatic logic [6:0] lzc64(input logic [WIDE_W-1:0] x);
		logic [6:0] n;
		n = 7'(WIDE_W);
		for (int i = 0; i < WIDE_W; i++) begin
			if (x[i]) n = 7'(WIDE_W - 1 - i);
		end
		return n;
	endfunction

endpackage

// ===== rtl/fmaf_pipe.sv =====
module fmaf_pipe (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic        last_in,
	output logic        out_vld,
	output logic [31:0] res,
	output logic        last_out
);

	// Valid bits travel with each stage.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= {in_vld, v_s1, v_s2, v_s3, v_s4, v_s5};
		end
	end

	// Stage 1: classify operands, resolve special cases, multiply significands.
	logic [7:0]  exa, exb, exc;
	logic [22:0] fra, frb, frc;
	logic        nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zro_a, zro_b, zro_c;
	logic        sp, sc;
	logic [23:0] ma, mb, mc;
	fmaf_pkg::exp_t ea, eb, ec;
	fmaf_pkg::spec_t spec;

	always_comb begin
		exa = a[30:23]; exb = b[30:23]; exc = c[30:23];
		fra = a[22:0];  frb = b[22:0];  frc = c[22:0];
		nan_a = (exa == 8'hFF) && (fra != '0);
		nan_b = (exb == 8'hFF) && (frb != '0);
		nan_c = (exc == 8'hFF) && (frc != '0);
		inf_a = (a[30:0] == fmaf_pkg::INF_BITS[30:0]);
		inf_b = (b[30:0] == fmaf_pkg::INF_BITS[30:0]);
		inf_c = (c[30:0] == fmaf_pkg::INF_BITS[30:0]);
		zro_a = (a[30:0] == '0);
		zro_b = (b[30:0] == '0);
		zro_c = (c[30:0] == '0);
		sp = a[31] ^ b[31];
		sc = c[31];
		ma = (exa == '0) ? {1'b0, fra} : {1'b1, fra};
		mb = (exb == '0) ? {1'b0, frb} : {1'b1, frb};
		mc = (exc == '0) ? {1'b0, frc} : {1'b1, frc};
		ea = (exa == '0) ? fmaf_pkg::exp_t'(1) - fmaf_pkg::EXP_OFFSET
		                 : fmaf_pkg::exp_t'({4'b0, exa}) - fmaf_pkg::EXP_OFFSET;
		eb = (exb == '0) ? fmaf_pkg::exp_t'(1) - fmaf_pkg::EXP_OFFSET
		                 : fmaf_pkg::exp_t'({4'b0, exb}) - fmaf_pkg::EXP_OFFSET;
		ec = (exc == '0) ? fmaf_pkg::exp_t'(1) - fmaf_pkg::EXP_OFFSET
		                 : fmaf_pkg::exp_t'({4'b0, exc}) - fmaf_pkg::EXP_OFFSET;
		spec.hit = 1'b1;
		spec.val = '0;
		if (nan_a) begin
			spec.val = a | fmaf_pkg::QUIET_BIT;
		end else if (nan_b) begin
			spec.val = b | fmaf_pkg::QUIET_BIT;
		end else if (nan_c) begin
			spec.val = c | fmaf_pkg::QUIET_BIT;
		end else if (inf_a || inf_b) begin
			if (zro_a || zro_b) spec.val = fmaf_pkg::QNAN_DEFAULT;
			else if (inf_c && (sc != sp)) spec.val = fmaf_pkg::QNAN_DEFAULT;
			else spec.val = {sp, fmaf_pkg::INF_BITS[30:0]};
		end else if (inf_c) begin
			spec.val = c;
		end else if (zro_a || zro_b) begin
			spec.val = zro_c ? {sp & sc, 31'b0} : c;
		end else begin
			spec.hit = 1'b0;
		end
	end

	logic [47:0]     prod_s1;
	fmaf_pkg::exp_t  ep_s1, ec_s1;
	logic [23:0]     mc_s1;
	logic            sp_s1, sc_s1, czero_s1, last_s1;
	fmaf_pkg::spec_t spec_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= ma * mb;
			ep_s1    <= ea + eb;
			ec_s1    <= ec;
			mc_s1    <= mc;
			sp_s1    <= sp;
			sc_s1    <= sc;
			czero_s1 <= zro_c;
			spec_s1  <= spec;
			last_s1  <= last_in;
		end
	end

	// Stage 2: justify both terms to bit 62 and order them by magnitude.
	logic [5:0]     lzp;
	logic [4:0]     lzc_c;
	logic [63:0]    mp_n, mc_n;
	fmaf_pkg::exp_t ep_n, ec_n;
	logic           prod_big;

	always_comb begin
		lzp   = fmaf_pkg::lzc48(prod_s1);
		lzc_c = fmaf_pkg::lzc24(mc_s1);
		mp_n  = {16'b0, prod_s1} << (7'd15 + 7'(lzp));
		ep_n  = ep_s1 - fmaf_pkg::exp_t'(7'd15 + 7'(lzp));
		mc_n  = {40'b0, mc_s1} << (7'd39 + 7'(lzc_c));
		ec_n  = ec_s1 - fmaf_pkg::exp_t'(7'd39 + 7'(lzc_c));
		prod_big = czero_s1 || (ep_n > ec_n) || ((ep_n == ec_n) && (mp_n >= mc_n));
	end

	logic [63:0]     big_s2, sml_s2;
	fmaf_pkg::exp_t  ebig_s2, dist_s2;
	logic            sbig_s2, sub_s2, last_s2;
	fmaf_pkg::spec_t spec_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			big_s2  <= prod_big ? mp_n : mc_n;
			sml_s2  <= czero_s1 ? '0 : (prod_big ? mc_n : mp_n);
			ebig_s2 <= prod_big ? ep_n : ec_n;
			dist_s2 <= prod_big ? (ep_n - ec_n) : (ec_n - ep_n);
			sbig_s2 <= prod_big ? sp_s1 : sc_s1;
			sub_s2  <= (sp_s1 != sc_s1);
			spec_s2 <= spec_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: align the smaller term with a sticky bit, then add or subtract.
	logic [63:0] sml_al, mr;
	logic [63:0] lo_mask;

	always_comb begin
		lo_mask = ~({64{1'b1}} << dist_s2[5:0]);
		if (dist_s2 >= fmaf_pkg::exp_t'(64)) begin
			sml_al = {63'b0, |sml_s2};
		end else begin
			sml_al = (sml_s2 >> dist_s2[5:0]) | {63'b0, |(sml_s2 & lo_mask)};
		end
		mr = sub_s2 ? (big_s2 - sml_al) : (big_s2 + sml_al);
	end

	logic [63:0]     mr_s3;
	fmaf_pkg::exp_t  e_s3;
	logic            sgn_s3, last_s3;
	fmaf_pkg::spec_t spec_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mr_s3   <= mr;
			e_s3    <= ebig_s2;
			sgn_s3  <= sbig_s2;
			last_s3 <= last_s2;
			if (!spec_s2.hit && (mr == '0)) spec_s3 <= '{hit: 1'b1, val: '0};
			else spec_s3 <= spec_s2;
		end
	end

	// Stage 4: normalize the sum to bit 63 and bias the exponent.
	logic [6:0] lzr;

	always_comb begin
		lzr = fmaf_pkg::lzc64(mr_s3);
	end

	logic [63:0]     m_s4;
	fmaf_pkg::exp_t  eb_s4;
	logic            sgn_s4, last_s4;
	fmaf_pkg::spec_t spec_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4    <= mr_s3 << lzr[5:0];
			eb_s4   <= e_s3 - fmaf_pkg::exp_t'(lzr) + fmaf_pkg::BIAS_ADJ;
			sgn_s4  <= sgn_s3;
			last_s4 <= last_s3;
			spec_s4 <= spec_s3;
		end
	end

	// Stage 5: pick the rounding position and form guard and sticky.
	fmaf_pkg::exp_t sh;
	logic [5:0]     shg;
	logic [63:0]    t;
	logic           guard, stk, flush;

	always_comb begin
		sh    = (eb_s4 >= fmaf_pkg::exp_t'(1)) ? fmaf_pkg::exp_t'(40)
		                                      : fmaf_pkg::exp_t'(41) - eb_s4;
		flush = (sh >= fmaf_pkg::exp_t'(65));
		shg   = 6'(sh - fmaf_pkg::exp_t'(1));
		t     = m_s4 >> shg;
		guard = t[0];
		stk   = |(m_s4 & ~({64{1'b1}} << shg));
	end

	logic [23:0]     q_s5;
	logic            up_s5, flush_s5, sgn_s5, last_s5;
	fmaf_pkg::exp_t  eb_s5;
	fmaf_pkg::spec_t spec_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s5     <= t[24:1];
			up_s5    <= guard && (stk || t[1]);
			flush_s5 <= flush;
			eb_s5    <= eb_s4;
			sgn_s5   <= sgn_s4;
			last_s5  <= last_s4;
			spec_s5  <= spec_s4;
		end
	end

	// Stage 6: round, pack and saturate to infinity.
	logic [24:0] qr;
	logic [33:0] bits;
	logic [31:0] packed_val;

	always_comb begin
		qr = {1'b0, q_s5} + {24'b0, up_s5};
		if (eb_s5 >= fmaf_pkg::exp_t'(1)) begin
			bits = ({22'b0, 12'(eb_s5 - fmaf_pkg::exp_t'(1))} << 23) + {9'b0, qr};
		end else begin
			bits = {9'b0, qr};
		end
		if (flush_s5) bits = '0;
		if (bits >= {2'b0, fmaf_pkg::INF_BITS}) bits = {2'b0, fmaf_pkg::INF_BITS};
		packed_val = {sgn_s5, bits[30:0]};
	end

	logic [31:0] res_s6;
	logic        last_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6  <= spec_s5.hit ? spec_s5.val : packed_val;
			last_s6 <= last_s5;
		end
	end

	assign out_vld  = v_s6;
	assign res      = res_s6;
	assign last_out = last_s6;

	// A stall freezes every valid bit in the pipeline.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6}))
		else $error("pipeline moved during stall");

	// An accepted item occupies the first stage on the next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_vld) |=> v_s1)
		else $error("accepted item lost at stage 1");

	// Every NaN that leaves the unit is quiet.
	a_quiet_nan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && (res_s6[30:23] == 8'hFF) && (res_s6[22:0] != '0)) |-> res_s6[22])
		else $error("signaling NaN produced");

endmodule

// ===== rtl/fused_multiply_add_float.sv =====
// Channel  | Group                      | Payload
// input    | s_tvalid s_tready s_tdata  | tdata: mult_a, mult_b, addend; tlast: last
// output   | m_tvalid m_tready m_tdata  | tdata: sum_value; tlast: last_res
//
// One transfer is accepted per cycle while the output is not stalled; each result
// passes through the six register stages of the datapath.
// arst_n clears all valid bits; payload registers are not reset.
// When the output is stalled the whole pipeline holds, so nothing is lost or repeated.
module fused_multiply_add_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // [31:0] mult_a, [63:32] mult_b, [95:64] addend
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sum_value
	output logic        m_tlast
);

	logic en;

	// The pipeline advances unless a finished result waits for a transfer.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	fmaf_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_tvalid),
		.a        (s_tdata[31:0]),
		.b        (s_tdata[63:32]),
		.c        (s_tdata[95:64]),
		.last_in  (s_tlast),
		.out_vld  (m_tvalid),
		.res      (m_tdata),
		.last_out (m_tlast)
	);

endmodule

// ===== dv/fma_checker.sv =====
`timescale 1ns / 100ps

module fma_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [31:0] sum_value;
		logic        last_res;
	} fma_result_t;

	fma_result_t expected_q[$];

	function automatic bit nan_bits(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction

	function automatic bit inf_bits(logic [31:0] x);
		return x[30:0] == fmaf_pkg::INF_BITS[30:0];
	endfunction

	function automatic bit zero_bits(logic [31:0] x);
		return x[30:0] == 0;
	endfunction

	// Normalize so the top set bit lands at position pos.
	function automatic void align_msb(inout logic [63:0] m, inout int e, input int pos);
		while (m[pos] == 1'b0) begin
			m = m << 1;
			e = e - 1;
		end
	endfunction

	function automatic void split(logic [31:0] x, output logic [63:0] m, output int e);
		if (x[30:23] == 0) begin
			m = {41'd0, x[22:0]};
			e = -149;
		end else begin
			m = {40'd0, 1'b1, x[22:0]};
			e = int'(x[30:23]) - 150;
		end
	endfunction

	// Round m * 2^e once, to nearest even, giving magnitude bits.
	function automatic logic [31:0] round_mag(logic [63:0] m, int e);
		int eb, s;
		logic [63:0] q, rem, half, bits;
		align_msb(m, e, 63);
		eb = e + 190;
		s = (eb >= 1) ? 40 : 41 - eb;
		if (s >= 65) return 0;
		if (s == 64) begin
			q = 0;
			rem = m;
		end else begin
			q = m >> s;
			rem = m & ((64'd1 << s) - 1);
		end
		half = 64'd1 << (s - 1);
		if (rem > half || (rem == half && q[0])) q = q + 1;
		bits = (eb >= 1) ? ((64'(eb - 1) << 23) + q) : q;
		if (bits >= 64'h7F80_0000) return fmaf_pkg::INF_BITS;
		return bits[31:0];
	endfunction

	function automatic logic [31:0] fused_mac(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		logic sp, sc, sbig;
		logic [63:0] ma, mb, mc, mp, mbig, msml, mr;
		int ea, eb, ec, ep, ebig, esml, d;
		sp = a[31] ^ b[31];
		sc = c[31];
		if (nan_bits(a)) return a | fmaf_pkg::QUIET_BIT;
		if (nan_bits(b)) return b | fmaf_pkg::QUIET_BIT;
		if (nan_bits(c)) return c | fmaf_pkg::QUIET_BIT;
		if (inf_bits(a) || inf_bits(b)) begin
			if (zero_bits(a) || zero_bits(b)) return fmaf_pkg::QNAN_DEFAULT;
			if (inf_bits(c) && sc != sp) return fmaf_pkg::QNAN_DEFAULT;
			return {sp, fmaf_pkg::INF_BITS[30:0]};
		end
		if (inf_bits(c)) return c;
		if (zero_bits(a) || zero_bits(b)) begin
			if (zero_bits(c)) return {sp & sc, 31'd0};
			return c;
		end
		split(a, ma, ea);
		split(b, mb, eb);
		mp = ma * mb;
		ep = ea + eb;
		align_msb(mp, ep, 62);
		if (zero_bits(c)) return {sp, 31'd0} | round_mag(mp, ep);
		split(c, mc, ec);
		align_msb(mc, ec, 62);
		if (ep > ec || (ep == ec && mp >= mc)) begin
			mbig = mp; ebig = ep; sbig = sp; msml = mc; esml = ec;
		end else begin
			mbig = mc; ebig = ec; sbig = sc; msml = mp; esml = ep;
		end
		// Align the smaller term, folding shifted-out bits into a sticky bit.
		d = ebig - esml;
		if (d >= 64) msml = (msml != 0) ? 64'd1 : 64'd0;
		else if (d > 0) msml = (msml >> d) | 64'(((msml & ((64'd1 << d) - 1)) != 0));
		mr = (sp == sc) ? mbig + msml : mbig - msml;
		if (mr == 0) return 0;
		return {sbig, 31'd0} | round_mag(mr, ebig);
	endfunction

	assign pending = expected_q.size();

	// Predict on each input transfer, compare on each output transfer.
	always @(posedge clk or negedge arst_n) begin
		fma_result_t exp_r;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				exp_r.sum_value = fused_mac(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
				exp_r.last_res = s_tlast;
				expected_q.push_back(exp_r);
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result transfer: sum_value %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r.sum_value !== m_tdata || exp_r.last_res !== m_tlast) begin
						if (exp_r.sum_value !== m_tdata)
							$error("sum_value: expected %h, got %h", exp_r.sum_value, m_tdata);
						if (exp_r.last_res !== m_tlast)
							$error("last_res: expected %b, got %b", exp_r.last_res, m_tlast);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== dv/tb_fused_multiply_add_float.sv =====
`timescale 1ns / 100ps

module tb_fused_multiply_add_float;
	localparam int RANDOM_ITEMS = 1430;
	localparam int STALL_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	int          fail_count;
	int          pending;
	bit          long_hold;
	bit          sending_done;
	int          idle_cycles;

	fused_multiply_add_float dut (.*);

	fma_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Operand mix weighted toward the interesting corners of binary32.
	function automatic logic [31:0] pick_operand();
		logic [31:0] x;
		x = $urandom();
		case ($urandom_range(0, 15))
			0: x[30:0] = 0;
			1: x[30:23] = 8'hFF;
			2: x[30:0] = 31'h7F80_0000;
			3: x[30:23] = 0;
			4: x[30:23] = 8'($urandom_range(100, 154));
			5: x[30:23] = 8'($urandom_range(230, 254));
			6: x[30:23] = 8'($urandom_range(1, 30));
			default: ;
		endcase
		return x;
	endfunction

	task automatic send_item(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic lst);
		s_tvalid <= 1'b1;
		s_tdata <= {c, b, a};
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_gap();
		int n;
		n = gap_len();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stimulus: corner cases first, then random operands.
	initial begin
		logic [31:0] a, b, c;
		s_tvalid = 0;
		s_tdata = 0;
		s_tlast = 0;
		sending_done = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_item(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 0);
		send_item(32'h7FA0_0001, 32'h0000_0000, 32'h7F80_0000, 0);
		send_item(32'h3F80_0000, 32'hFF80_0001, 32'h7FC0_1234, 0);
		send_item(32'h3F80_0000, 32'h4000_0000, 32'hFF81_0000, 1);
		send_item(32'h0000_0000, 32'h7F80_0000, 32'h3F80_0000, 0);
		send_item(32'hFF80_0000, 32'h3F80_0000, 32'h7F80_0000, 0);
		send_item(32'h7F80_0000, 32'hC000_0000, 32'hFF80_0000, 0);
		send_item(32'h3F80_0000, 32'h4000_0000, 32'hFF80_0000, 0);
		send_item(32'h8000_0000, 32'h3F80_0000, 32'h8000_0000, 1);
		send_item(32'h0000_0000, 32'h3F80_0000, 32'h8000_0000, 0);
		send_item(32'h8000_0000, 32'h0000_0000, 32'h4120_0000, 0);
		send_item(32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 0);
		send_item(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000, 0);
		send_item(32'h7F7F_FFFF, 32'h4000_0000, 32'h7F7F_FFFF, 1);
		send_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 0);
		send_item(32'h0000_0001, 32'h3F00_0000, 32'h8000_0000, 0);
		send_item(32'h0000_0003, 32'h3F00_0000, 32'h0000_0000, 0);
		send_item(32'h007F_FFFF, 32'h3F80_0000, 32'h0000_0001, 0);
		send_item(32'h3F80_0001, 32'h3F80_0001, 32'hBF80_0002, 0);
		send_item(32'h3F80_0000, 32'h3380_0000, 32'h3F80_0000, 1);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			send_gap();
			a = pick_operand();
			b = pick_operand();
			c = pick_operand();
			// Some addends sit near -a*b to provoke deep cancellation.
			if ($urandom_range(0, 7) == 0) begin
				a = pick_operand();
				b = 32'h3F80_0000;
				c = {~a[31], a[30:2], 2'($urandom())};
			end
			send_item(a, b, c, 1'($urandom()));
		end
		s_tvalid <= 1'b0;
		sending_done <= 1'b1;
	end

	// Receiver: random backpressure, with one long hold-off early on.
	initial begin
		m_tready = 0;
		long_hold = 0;
		@(posedge arst_n);
		repeat (60) begin
			@(posedge clk);
			m_tready <= ($urandom_range(0, 3) != 0);
		end
		m_tready <= 1'b0;
		long_hold = 1;
		repeat (200) @(posedge clk);
		long_hold = 0;
		forever begin
			if (gap_len() == 0 || $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (gap_len() + 1) @(posedge clk);
			end
		end
	end

	// Watchdog and verdict.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || long_hold)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[fused_multiply_add_float] ERROR");
				$finish;
			end
			if (sending_done && pending == 0) begin
				repeat (20) @(posedge clk);
				if (fail_count == 0 && pending == 0)
					$display("[fused_multiply_add_float] OK");
				else
					$display("[fused_multiply_add_float] ERROR");
				$finish;
			end
		end
	end
endmodule

// ===== filelist.f =====
rtl/fmaf_pkg.sv
rtl/fmaf_pipe.sv
rtl/fused_multiply_add_float.sv
dv/fma_checker.sv
dv/tb_fused_multiply_add_float.sv
